// ===== hw/rtl/ecdsa_der_pkg.sv =====
// ----------------------------------------------------------------------------
// ecdsa_der_pkg
// Types and constants shared by the signature DER encoder modules.
// ----------------------------------------------------------------------------
package ecdsa_der_pkg;

  localparam int HALF_BYTES  = 32;
  localparam int WORD_BITS   = 64;
  localparam int MAX_WORDS   = 9;
  localparam int DER_BITS    = MAX_WORDS * WORD_BITS;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] TAG_SEQ = 8'h30;
  localparam logic [7:0] TAG_INT = 8'h02;
  localparam logic [7:0] PAD_BYTE = 8'h00;

  typedef struct packed {
    logic [63:0] r_word0;
    logic [63:0] r_word1;
    logic [63:0] r_word2;
    logic [63:0] r_word3;
    logic [63:0] s_word0;
    logic [63:0] s_word1;
    logic [63:0] s_word2;
    logic [63:0] s_word3;
  } in_t;

  typedef struct packed {
    logic [63:0] der_word;
    logic [3:0]  valid_bytes;
    logic [6:0]  total_length;
    logic        last_word;
  } out_t;

  // classified signature, passed from front to back
  typedef struct packed {
    logic [255:0] r;
    logic [255:0] s;
    logic [5:0]   first_r;
    logic [5:0]   first_s;
    logic         pad_r;
    logic         pad_s;
    logic [5:0]   len_r;
    logic [5:0]   len_s;
    logic [6:0]   total;
  } cls_t;

endpackage

// ===== hw/rtl/ecdsa_der_front.sv =====
// ----------------------------------------------------------------------------
// ecdsa_der_front
// Finds the leading zero bytes and pad need of R and S, and the lengths.
// ----------------------------------------------------------------------------
module ecdsa_der_front (
  input  ecdsa_der_pkg::in_t  signature,
  output ecdsa_der_pkg::cls_t cls
);

  logic [255:0] r;
  logic [255:0] s;
  logic [5:0]   first_r;
  logic [5:0]   first_s;
  logic         top_r;
  logic         top_s;
  logic [5:0]   len_r;
  logic [5:0]   len_s;

  assign r = {signature.r_word0, signature.r_word1, signature.r_word2, signature.r_word3};
  assign s = {signature.s_word0, signature.s_word1, signature.s_word2, signature.s_word3};

  // first non-zero byte, or 32 when all zero
  always_comb begin
    first_r = 6'(ecdsa_der_pkg::HALF_BYTES);
    first_s = 6'(ecdsa_der_pkg::HALF_BYTES);
    top_r   = 1'b0;
    top_s   = 1'b0;
    for (int i = ecdsa_der_pkg::HALF_BYTES - 1; i >= 0; i--) begin
      if (r[255 - 8 * i -: 8] != 8'h00) begin
        first_r = 6'(i);
        top_r   = r[255 - 8 * i];
      end
      if (s[255 - 8 * i -: 8] != 8'h00) begin
        first_s = 6'(i);
        top_s   = s[255 - 8 * i];
      end
    end
  end

  assign len_r = 6'(6'(ecdsa_der_pkg::HALF_BYTES) - first_r) + {5'b0, top_r};
  assign len_s = 6'(6'(ecdsa_der_pkg::HALF_BYTES) - first_s) + {5'b0, top_s};

  always_comb begin
    cls.r       = r;
    cls.s       = s;
    cls.first_r = first_r;
    cls.first_s = first_s;
    cls.pad_r   = top_r;
    cls.pad_s   = top_s;
    cls.len_r   = len_r;
    cls.len_s   = len_s;
    cls.total   = 7'd6 + {1'b0, len_r} + {1'b0, len_s};
  end

endmodule

// ===== hw/rtl/ecdsa_der_queue.sv =====
// ----------------------------------------------------------------------------
// ecdsa_der_queue
// Short queue of classified signatures between front and back.
// ----------------------------------------------------------------------------
module ecdsa_der_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ecdsa_der_pkg::cls_t  wr_data,
  output logic                 full,
  input  logic                 pop,
  output ecdsa_der_pkg::cls_t  rd_data,
  output logic                 valid
);

  localparam int PTR_W = (ecdsa_der_pkg::QUEUE_DEPTH > 1) ?
                         $clog2(ecdsa_der_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ecdsa_der_pkg::QUEUE_DEPTH + 1);

  ecdsa_der_pkg::cls_t entries [ecdsa_der_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(ecdsa_der_pkg::QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(ecdsa_der_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(ecdsa_der_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ecdsa_der_back.sv =====
// ----------------------------------------------------------------------------
// ecdsa_der_back
// Builds the DER encoding of one signature and emits it word by word.
// ----------------------------------------------------------------------------
module ecdsa_der_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  ecdsa_der_pkg::cls_t q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output ecdsa_der_pkg::out_t encoding
);

  logic [63:0]  encoded_buffer [ecdsa_der_pkg::MAX_WORDS];
  logic [63:0]  buf_next [ecdsa_der_pkg::MAX_WORDS];
  logic [3:0]   emit_index;
  logic [6:0]   encoded_length;
  logic         loaded;

  logic [255:0] rn;
  logic [255:0] sn;
  logic [279:0] rblk;
  logic [279:0] sblk;
  logic [6:0]   seq_len;
  logic [6:0]   s_ofs;
  logic [ecdsa_der_pkg::DER_BITS-1:0] der_head;
  logic [ecdsa_der_pkg::DER_BITS-1:0] der;

  logic [3:0]   words;
  logic         last;
  logic         finish;
  logic         load;

  // normalise, then place tags, lengths and pads
  assign rn = q_data.r << {q_data.first_r, 3'b000};
  assign sn = q_data.s << {q_data.first_s, 3'b000};
  assign rblk = {ecdsa_der_pkg::TAG_INT, 2'b00, q_data.len_r,
                 q_data.pad_r ? {ecdsa_der_pkg::PAD_BYTE, rn} : {rn, 8'h00}};
  assign sblk = {ecdsa_der_pkg::TAG_INT, 2'b00, q_data.len_s,
                 q_data.pad_s ? {ecdsa_der_pkg::PAD_BYTE, sn} : {sn, 8'h00}};
  assign seq_len  = q_data.total - 7'd2;
  assign s_ofs    = 7'd4 + {1'b0, q_data.len_r};
  assign der_head = {ecdsa_der_pkg::TAG_SEQ, 1'b0, seq_len, rblk, 280'b0};
  assign der      = der_head | ({sblk, 296'b0} >> {s_ofs, 3'b000});

  always_comb begin
    for (int w = 0; w < ecdsa_der_pkg::MAX_WORDS; w++) begin
      buf_next[w] = der[ecdsa_der_pkg::DER_BITS - 1 - ecdsa_der_pkg::WORD_BITS * w -: 64];
    end
  end

  assign words  = 4'((encoded_length + 7'd7) >> 3);
  assign last   = (emit_index + 4'd1 == words);
  assign finish = loaded && pop && last;
  assign load   = q_valid && (!loaded || finish);
  assign q_pop  = load;
  assign empty  = !loaded;

  always_comb begin
    encoding.der_word     = encoded_buffer[emit_index];
    encoding.valid_bytes  = last ? 4'(encoded_length - {emit_index, 3'b000}) : 4'd8;
    encoding.total_length = encoded_length;
    encoding.last_word    = last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      encoded_buffer <= buf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded         <= 1'b0;
      emit_index     <= '0;
      encoded_length <= '0;
    end else if (load) begin
      loaded         <= 1'b1;
      emit_index     <= '0;
      encoded_length <= q_data.total;
    end else if (finish) begin
      loaded         <= 1'b0;
    end else if (loaded && pop) begin
      emit_index     <= emit_index + 4'd1;
    end
  end

endmodule

// ===== hw/rtl/ecdsa_signature_der_encoder.sv =====
// ----------------------------------------------------------------------------
// ecdsa_signature_der_encoder
// Encodes a raw 64-byte ECDSA signature (R then S) as a DER SEQUENCE.
// ----------------------------------------------------------------------------
// Input queue side: a signature transfer takes place when push is high and
// full is low. Output queue side: while empty is low the oldest DER word is
// on encoding; it transfers when pop is high.
// Each signature gives ceil(length/8) words, 1 to 9, the last flagged by
// last_word, each with its valid byte count and the total length.
// A signature is registered in the queue and then in the output buffer
// before its first word shows on encoding.
// Throughput: one word per cycle while pop is high; the nine-word output
// buffer loads the next signature as the last word of one transfers.
// The front classifies in the transfer cycle and a two-entry queue holds
// classified signatures, so input is taken while the back still emits.
// When pop stays low the current word holds, the queue fills and full rises.
// Reset empties the queue and the output; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ecdsa_signature_der_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ecdsa_der_pkg::in_t  signature,
  output logic                empty,
  input  logic                pop,
  output ecdsa_der_pkg::out_t encoding
);

  ecdsa_der_pkg::cls_t cls;
  ecdsa_der_pkg::cls_t q_data;
  logic                q_valid;
  logic                q_pop;

  ecdsa_der_front u_front (
    .signature (signature),
    .cls       (cls)
  );

  ecdsa_der_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cls),
    .full    (full),
    .pop     (q_pop),
    .rd_data (q_data),
    .valid   (q_valid)
  );

  ecdsa_der_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .encoding (encoding)
  );

`ifndef SYNTHESIS
  a_valid_range : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (encoding.valid_bytes != 4'd0 && encoding.valid_bytes <= 4'd8))
    else $error("valid byte count out of range");

  a_full_words : assert property (@(posedge clk) disable iff (rst)
    (!empty && !encoding.last_word) |-> (encoding.valid_bytes == 4'd8))
    else $error("partial word before the last word");

  a_length_held : assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !encoding.last_word) |=>
    (!empty && $stable(encoding.total_length)))
    else $error("encoding broken off before its last word");

  a_length_min : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (encoding.total_length >= 7'd6 && encoding.total_length <= 7'd72))
    else $error("total length out of range");
`endif

endmodule

// ===== verif/tb_ecdsa_signature_der_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_ecdsa_signature_der_encoder
// Self-checking bench for the signature DER encoder. Raw R/S signatures are
// pushed through the input queue, each is DER-encoded by a local predictor
// and every popped word is compared field by field with the oldest one
// predicted. Directed corner signatures come first, then random ones in
// blocks with random idle gaps on both sides, on one side or on neither.
// ----------------------------------------------------------------------------
module tb_ecdsa_signature_der_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_SIGS = 400;
  localparam int BLOCK_SIGS  = 50;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 16;

  class der_word_tracker;
    ecdsa_der_pkg::out_t pending_words[$];
    int   mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // encode one signature and queue the words it must produce
    function void note_signature(ecdsa_der_pkg::in_t sig);
      logic [511:0] flat;
      logic [7:0]   raw[64];
      logic [7:0]   der[72];
      logic [63:0]  w;
      ecdsa_der_pkg::out_t word;
      int           i, b, h, k, first, lenpos, pos, nwords;
      flat = sig;
      for (i = 0; i < 64; i++) raw[i] = flat[511 - 8 * i -: 8];
      for (i = 0; i < 72; i++) der[i] = 8'h00;
      der[0] = ecdsa_der_pkg::TAG_SEQ;
      pos = 2;
      for (h = 0; h < 2; h++) begin
        first = 0;
        while (first < ecdsa_der_pkg::HALF_BYTES &&
               raw[h * ecdsa_der_pkg::HALF_BYTES + first] == 8'h00) first++;
        der[pos] = ecdsa_der_pkg::TAG_INT;
        lenpos = pos + 1;
        pos = pos + 2;
        if (first < ecdsa_der_pkg::HALF_BYTES &&
            raw[h * ecdsa_der_pkg::HALF_BYTES + first][7]) begin
          der[pos] = ecdsa_der_pkg::PAD_BYTE;
          pos++;
        end
        for (k = first; k < ecdsa_der_pkg::HALF_BYTES; k++) begin
          der[pos] = raw[h * ecdsa_der_pkg::HALF_BYTES + k];
          pos++;
        end
        der[lenpos] = 8'(pos - lenpos - 1);
      end
      der[1] = 8'(pos - 2);
      nwords = (pos + 7) / 8;
      for (i = 0; i < nwords; i++) begin
        w = '0;
        for (b = 0; b < 8; b++) w = {w[55:0], der[i * 8 + b]};
        word.der_word     = w;
        word.valid_bytes  = (i + 1 < nwords) ? 4'd8 : 4'(pos - 8 * i);
        word.total_length = 7'(pos);
        word.last_word    = (i + 1 == nwords);
        pending_words.insert(pending_words.size(), word);
      end
    endfunction

    function void check_word(ecdsa_der_pkg::out_t got);
      ecdsa_der_pkg::out_t exp;
      if (pending_words.size() == 0) begin
        $error("unexpected word der_word %h", got.der_word);
        mismatch_count++;
        return;
      end
      exp = pending_words.pop_front();
      if (got.der_word !== exp.der_word) begin
        $error("der_word expected %h actual %h", exp.der_word, got.der_word);
        mismatch_count++;
      end
      if (got.valid_bytes !== exp.valid_bytes) begin
        $error("valid_bytes expected %0d actual %0d", exp.valid_bytes, got.valid_bytes);
        mismatch_count++;
      end
      if (got.total_length !== exp.total_length) begin
        $error("total_length expected %0d actual %0d", exp.total_length, got.total_length);
        mismatch_count++;
      end
      if (got.last_word !== exp.last_word) begin
        $error("last_word expected %0d actual %0d", exp.last_word, got.last_word);
        mismatch_count++;
      end
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  ecdsa_der_pkg::in_t  signature = '0;
  ecdsa_der_pkg::out_t encoding;

  der_word_tracker tracker;
  int tx_gap_max = 8;
  int rx_gap_max = 8;
  int cycle_count = 0;

  ecdsa_signature_der_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .signature (signature),
    .empty     (empty),
    .pop       (pop),
    .encoding  (encoding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_signature(input logic [255:0] r, input logic [255:0] s);
    int gap;
    ecdsa_der_pkg::in_t sig;
    gap = $urandom_range(0, tx_gap_max);
    sig = {r, s};
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    signature <= sig;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_signature(sig);
  endtask

  task automatic take_words();
    int gap;
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      tracker.check_word(encoding);
    end
  endtask

  // mostly full-width integers, some with leading zero bytes, zero or all ones
  function automatic logic [255:0] random_integer();
    logic [255:0] v;
    int j, mode;
    v = '0;
    for (j = 0; j < 8; j++) v = {v[223:0], 32'($urandom)};
    mode = $urandom_range(0, 15);
    if (mode == 0) v = '0;
    else if (mode == 1) v = '1;
    else if (mode <= 5) v = v >> (8 * $urandom_range(1, 32));
    else if (mode == 6) v = v >> $urandom_range(1, 255);
    return v;
  endfunction

  initial begin
    int n, blk;
    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    fork
      take_words();
    join_none

    // directed corners: zero integers, pad bytes, leading zeros, extremes
    send_signature('0, '0);
    send_signature('1, '1);
    send_signature(256'd1, 256'd1);
    send_signature(256'h80, 256'h7f);
    send_signature({8'h80, 248'h0}, {8'h7f, 248'h0});
    send_signature('0, '1);
    send_signature('1, '0);
    send_signature({8'h00, {248{1'b1}}}, {16'h0001, 240'h0});
    send_signature({8'h7f, {248{1'b1}}}, {8'h80, 248'h0});
    send_signature(256'h1 << 255, 256'd1);
    send_signature({32{8'haa}}, {32{8'h55}});
    send_signature({31{8'h00}} << 8 | 256'h80, '0);
    send_signature({{31{8'h00}}, 8'h01}, {{30{8'h00}}, 16'h8000});
    send_signature({8'hff, 248'h0}, {8'h01, {31{8'hff}}});

    for (blk = 0; blk < RANDOM_SIGS / BLOCK_SIGS; blk++) begin
      tx_gap_max = (blk % 4 == 1 || blk % 4 == 3) ? 0 : 8;
      rx_gap_max = (blk % 4 == 2 || blk % 4 == 3) ? 0 : 8;
      for (n = 0; n < BLOCK_SIGS; n++) send_signature(random_integer(), random_integer());
    end
    push <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
